// ===== src/keyed_crc32_checksum_defines.svh =====
// Assertion helpers for the keyed checksum block
`ifndef KEYED_CRC32_CHECKSUM_DEFINES_SVH
`define KEYED_CRC32_CHECKSUM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KCRC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define KCRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kcrc_pkg.sv =====
`timescale 1ns / 1ps

package kcrc_pkg;

    localparam int KEY_LENGTH = 45;
    localparam int KEY_POS_W  = 6;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [KEY_POS_W:0] KEY_LEN_V = (KEY_POS_W + 1)'(KEY_LENGTH);

    typedef logic [KEY_POS_W-1:0] key_pos_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } kcrc_item_t;

    function automatic logic [7:0] key_byte(input key_pos_t idx);
        logic [7:0] k;
        unique case (idx)
            6'd0:  k = 8'h66;  6'd1:  k = 8'h30;  6'd2:  k = 8'h70;  6'd3:  k = 8'h65;
            6'd4:  k = 8'h73;  6'd5:  k = 8'h73;  6'd6:  k = 8'h64;  6'd7:  k = 8'h66;
            6'd8:  k = 8'h39;  6'd9:  k = 8'h38;  6'd10: k = 8'h34;  6'd11: k = 8'h33;
            6'd12: k = 8'h6E;  6'd13: k = 8'h26;  6'd14: k = 8'h5E;  6'd15: k = 8'h67;
            6'd16: k = 8'h39;  6'd17: k = 8'h32;  6'd18: k = 8'h33;  6'd19: k = 8'h74;
            6'd20: k = 8'h72;  6'd21: k = 8'h68;  6'd22: k = 8'h60;  6'd23: k = 8'h31;
            6'd24: k = 8'h75;  6'd25: k = 8'h39;  6'd26: k = 8'h66;  6'd27: k = 8'h39;
            6'd28: k = 8'h77;  6'd29: k = 8'h66;  6'd30: k = 8'h32;  6'd31: k = 8'h33;
            6'd32: k = 8'h38;  6'd33: k = 8'h37;  6'd34: k = 8'h68;  6'd35: k = 8'h6A;
            6'd36: k = 8'h6B;  6'd37: k = 8'h5E;  6'd38: k = 8'hA3;  6'd39: k = 8'h34;
            6'd40: k = 8'h67;  6'd41: k = 8'h62;  6'd42: k = 8'h68;  6'd43: k = 8'h6A;
            6'd44: k = 8'h69;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    // Fold out-of-range positions back to the start of the key
    function automatic key_pos_t clamp_pos(input key_pos_t pos);
        key_pos_t r;
        r = ({1'b0, pos} >= KEY_LEN_V) ? '0 : pos;
        return r;
    endfunction

    function automatic key_pos_t advance_pos(input key_pos_t pos);
        logic [KEY_POS_W:0] nxt;
        key_pos_t r;
        nxt = {1'b0, pos} + 1'b1;
        r   = (nxt >= KEY_LEN_V) ? '0 : nxt[KEY_POS_W-1:0];
        return r;
    endfunction

    // Shift eight bits, least significant first
    function automatic logic [31:0] shift_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[30:0], 1'b0} ^ (r[31] ? CRC_POLY : 32'h0) ^ {31'h0, b[i]};
        end
        return r;
    endfunction

endpackage

// ===== src/kcrc_input_stage.sv =====
`timescale 1ns / 1ps

module kcrc_input_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // data_byte
    input  logic               s_axis_tuser,  // first_byte
    input  logic               s_axis_tlast,  // last_byte
    output logic               item_valid,
    output kcrc_pkg::kcrc_item_t item,
    input  logic               item_take
);
    import kcrc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    kcrc_item_t item_reg;

    assign s_axis_tready = !valid_reg || item_take;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= '{data_byte: s_axis_tdata, first_byte: s_axis_tuser,
                          last_byte: s_axis_tlast};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/kcrc_core.sv =====
`timescale 1ns / 1ps

module kcrc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  kcrc_pkg::kcrc_item_t item,
    output logic                 item_take,
    input  logic                 result_ready,
    output logic                 result_load,
    output logic [31:0]          result_crc,
    output kcrc_pkg::key_pos_t   key_pos
);
    import kcrc_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    key_pos_t    key_pos_reg;
    key_pos_t    key_pos_next;
    logic [31:0] crc_base;
    key_pos_t    pos_cur;

    // Hold a last item until the result register has room
    assign item_take   = item_valid && (!item.last_byte || result_ready);
    assign result_load = item_take && item.last_byte;

    always_comb
    begin
        crc_base     = item.first_byte ? 32'h0 : crc_reg;
        pos_cur      = clamp_pos(item.first_byte ? key_pos_t'(0) : key_pos_reg);
        crc_next     = shift_byte(crc_base, item.data_byte ^ key_byte(pos_cur));
        key_pos_next = advance_pos(pos_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= 32'h0;
            key_pos_reg <= '0;
        end
        else if (item_take)
        begin
            crc_reg     <= crc_next;
            key_pos_reg <= key_pos_next;
        end
    end

    assign result_crc = crc_next;
    assign key_pos    = key_pos_reg;

endmodule

// ===== src/kcrc_output_stage.sv =====
`timescale 1ns / 1ps

module kcrc_output_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_load,
    input  logic [31:0] result_crc,
    output logic        result_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // checksum
);
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] data_reg;

    assign result_ready = !valid_reg || m_axis_tready;
    assign valid_next   = result_load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            data_reg <= result_crc;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

// ===== src/keyed_crc32_checksum.sv =====
// Keyed 32-bit checksum over byte records. Each byte on the input stream is
// XORed with the next byte of a fixed 45-byte key and then shifted, LSB first,
// into a 32-bit register with polynomial 0x04C11DB7. tuser marks the first
// byte of a record (clears the register and key position), tlast the final
// byte, after which one 32-bit checksum item appears on the output stream.
// One byte is taken per cycle while the input is not stalled; an item passes
// an input register, and the checksum of a last byte goes from the core's
// combinational result into the output register when that byte is taken. The
// input stalls only when a last byte finds the output register still full.
`timescale 1ns / 1ps

`include "keyed_crc32_checksum_defines.svh"

module keyed_crc32_checksum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] checksum
);
    import kcrc_pkg::*;

    logic        item_valid;
    kcrc_item_t  item;
    logic        item_take;
    logic        result_ready;
    logic        result_load;
    logic [31:0] result_crc;
    key_pos_t    key_pos;

    kcrc_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    kcrc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .result_ready (result_ready),
        .result_load  (result_load),
        .result_crc   (result_crc),
        .key_pos      (key_pos)
    );

    kcrc_output_stage u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .result_load   (result_load),
        .result_crc    (result_crc),
        .result_ready  (result_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `KCRC_ASSERT_NEXT(a_last_gives_result, result_load, m_axis_tvalid,
                      "last item gave no checksum")
    `KCRC_ASSERT_NOW(a_stall_needs_item, !s_axis_tready, item_valid,
                     "input stalled while empty")
    `KCRC_ASSERT_NEXT(a_first_restarts_key, item_take && item.first_byte,
                      key_pos == advance_pos(key_pos_t'(0)), "key position not restarted")

endmodule
